// ----- sv/wsa_pkg.sv -----
// ----------------------------------------------------------------------------
// wsa_pkg
// Shared types, widths and helpers for the windowed speed average block.
// ----------------------------------------------------------------------------
`default_nettype none

package wsa_pkg;

  localparam int MAX_WINDOW = 32;
  localparam int SAMPLE_W   = 16;
  localparam int CFG_W      = 6;
  localparam int CFG_RESET  = 8;
  localparam int POS_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LEN_W      = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W      = SAMPLE_W + LEN_W;
  localparam int REM_W      = LEN_W + 1;
  localparam int CNT_W      = $clog2(SUM_W);

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [CFG_W-1:0]    cfg_t;
  typedef logic [LEN_W-1:0]    len_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [SUM_W-1:0]    sum_t;
  typedef logic [REM_W-1:0]    rem_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_HOLD
  } state_t;

  // zero maps to one, anything above the store depth saturates
  function automatic len_t eff_len(input cfg_t w);
    len_t r;
    if (w == '0) begin
      r = len_t'(1);
    end else if (int'(w) > MAX_WINDOW) begin
      r = len_t'(MAX_WINDOW);
    end else begin
      r = len_t'(w);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/wsa_ifs.sv -----
// ----------------------------------------------------------------------------
// wsa_ifs
// Valid/ready channels for speed samples in and averages out.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsa_sample_if;
  import wsa_pkg::*;

  logic    valid;
  logic    ready;
  sample_t speed_sample;

  modport source (output valid, output speed_sample, input ready);
  modport sink   (input valid, input speed_sample, output ready);
endinterface

interface wsa_average_if;
  import wsa_pkg::*;

  logic    valid;
  logic    ready;
  sample_t average_speed;

  modport source (output valid, output average_speed, input ready);
  modport sink   (input valid, input average_speed, output ready);
endinterface

`default_nettype wire

// ----- sv/windowed_speed_average.sv -----
// ----------------------------------------------------------------------------
// windowed_speed_average
// Moving average over a ring of speed samples, summed one entry per cycle
// and divided by the window length with a bit-serial restoring divider.
//
//   channel   dir   payload              transfer when
//   sample    in    speed_sample[15:0]   sample.valid & sample.ready
//   average   out   average_speed[15:0]  average.valid & average.ready
//   cfg       in    cfg_wdata[5:0]       cfg_we
//
// Each item runs from transfer through the accumulate loop over L entries of
// the store, L being the effective window, then the shift-subtract divider
// and a handoff step into the result register.
// A new sample is taken while the previous result waits in the output
// register; the engine stalls only in its handoff step.
// Synchronous reset clears the store and ring position and sets the window to 8.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_speed_average (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [wsa_pkg::CFG_W-1:0] cfg_wdata,
  wsa_sample_if.sink            sample,
  wsa_average_if.source         average
);
  import wsa_pkg::*;

  cfg_t    window_length;
  sample_t store [MAX_WINDOW];
  pos_t    write_position;
  state_t  state, state_next;
  len_t    len;
  pos_t    idx;
  sum_t    acc;
  rem_t    rem;
  cnt_t    div_cnt;
  logic    out_valid;
  sample_t out_data;

  logic    in_ready;
  logic    accept;
  logic    load_out;
  logic    sum_last;
  logic    div_last;
  len_t    len_cfg;
  len_t    pos_inc;
  pos_t    pos_next;
  sum_t    sum_next;
  rem_t    trial;
  logic    qbit;

  assign accept  = sample.valid && in_ready;
  assign len_cfg = eff_len(window_length);
  assign pos_inc = len_t'(write_position) + len_t'(1);
  assign pos_next = (pos_inc >= len_cfg) ? '0 : pos_inc[POS_W-1:0];

  assign sum_next = acc + sum_t'(store[idx]);
  assign sum_last = (len_t'(idx) + len_t'(1)) == len;

  assign trial    = {rem[LEN_W-1:0], acc[SUM_W-1]};
  assign qbit     = trial >= rem_t'(len);
  assign div_last = div_cnt == cnt_t'(SUM_W - 1);

  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_HOLD: load_out = !out_valid || average.ready;
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_SUM;
      ST_SUM:  if (sum_last) state_next = ST_DIV;
      ST_DIV:  if (div_last) state_next = ST_HOLD;
      ST_HOLD: if (load_out) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= cfg_t'(CFG_RESET);
    end else if (cfg_we) begin
      window_length <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
        store[i] <= '0;
      end
      write_position <= '0;
    end else if (accept) begin
      store[write_position] <= sample.speed_sample;
      write_position        <= pos_next;
    end
  end

  // accumulate then shift-subtract divide, quotient lands in acc
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        len <= len_cfg;
        idx <= '0;
        acc <= '0;
      end
      ST_SUM: begin
        acc     <= sum_next;
        idx     <= idx + pos_t'(1);
        rem     <= '0;
        div_cnt <= '0;
      end
      ST_DIV: begin
        rem     <= qbit ? trial - rem_t'(len) : trial;
        acc     <= {acc[SUM_W-2:0], qbit};
        div_cnt <= div_cnt + cnt_t'(1);
      end
      ST_HOLD: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (average.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= acc[SAMPLE_W-1:0];
    end
  end

  assign sample.ready          = in_ready;
  assign average.valid         = out_valid;
  assign average.average_speed = out_data;

endmodule

`default_nettype wire

// ----- sv/wsa_checker.sv -----
// ----------------------------------------------------------------------------
// wsa_checker
// Port-level checks on the windowed speed average, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wsa_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      sample_valid,
  input logic                      sample_ready,
  input logic                      average_valid,
  input logic                      average_ready,
  input logic [wsa_pkg::SAMPLE_W-1:0] average_speed
);
  import wsa_pkg::*;

  logic sample_xfer;
  assign sample_xfer = sample_valid && sample_ready;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    average_valid && !average_ready |=> average_valid && $stable(average_speed))
    else $error("average dropped or changed while stalled");

  // one sample at a time in the engine
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    sample_xfer |=> !sample_ready)
    else $error("sample taken while engine busy");

  // result never appears right after a sample transfer
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    sample_xfer |=> !$rose(average_valid))
    else $error("result produced without computation time");

  // a new result is loaded only from an idle-to-busy item
  a_rise_needs_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(average_valid) |-> !$past(sample_ready))
    else $error("result appeared while engine idle");

endmodule

bind windowed_speed_average wsa_checker u_wsa_checker (
  .clk           (clk),
  .rst           (rst),
  .sample_valid  (sample.valid),
  .sample_ready  (sample.ready),
  .average_valid (average.valid),
  .average_ready (average.ready),
  .average_speed (average.average_speed)
);

`default_nettype wire
